// File: rtl/tst_pkg.sv
`default_nettype none

package tst_pkg;

  localparam int COORD_W     = 12;
  localparam int CNT_W       = 32;
  localparam int TOUCH_W     = 4;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_TOUCHES = 5;

  localparam logic [CFG_W-1:0] MAX_X_RST        = CFG_W'(799);
  localparam logic [CFG_W-1:0] MAX_Y_RST        = CFG_W'(479);
  localparam logic [CFG_W-1:0] SWIPE_MIN_DX_RST = CFG_W'(80);
  localparam logic [CFG_W-1:0] SWIPE_MAX_DY_RST = CFG_W'(120);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_X        = 2'd0,
    REG_MAX_Y        = 2'd1,
    REG_SWIPE_MIN_DX = 2'd2,
    REG_SWIPE_MAX_DY = 2'd3
  } tst_reg_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_DOWN    = 2'd1,
    EV_CONTACT = 2'd2,
    EV_LIFT    = 2'd3
  } tst_event_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_x;
    logic [CFG_W-1:0] max_y;
    logic [CFG_W-1:0] swipe_min_dx;
    logic [CFG_W-1:0] swipe_max_dy;
  } tst_cfg_t;

  typedef struct packed {
    logic               bus_ok;
    logic [1:0]         ev_code;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
    logic [TOUCH_W-1:0] touch_count;
  } tst_in_t;

  typedef struct packed {
    logic               pressed;
    logic [COORD_W-1:0] last_x;
    logic [COORD_W-1:0] last_y;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [CNT_W-1:0]   poll_cnt;
    logic [CNT_W-1:0]   good_cnt;
    logic [CNT_W-1:0]   error_cnt;
    logic [CNT_W-1:0]   press_cnt;
    logic [CNT_W-1:0]   swipe_cnt;
    logic [TOUCH_W-1:0] touches;
  } tst_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               is_pressed;
    logic               bus_error;
    logic               swipe_valid;
    logic               swipe_right;
    logic [CNT_W-1:0]   poll_count;
    logic [CNT_W-1:0]   good_count;
    logic [CNT_W-1:0]   err_polls;
    logic [CNT_W-1:0]   press_polls;
    logic [CNT_W-1:0]   swipe_total;
    logic [TOUCH_W-1:0] last_touches;
  } tst_res_t;

endpackage

`default_nettype wire

// File: rtl/tst_step.sv
`default_nettype none

module tst_step import tst_pkg::*; (
  input  tst_cfg_t   cfg,
  input  tst_state_t st,
  input  tst_in_t    item,
  output tst_state_t st_nxt,
  output tst_res_t   res
);

  logic [COORD_W-1:0] map_x;
  logic [COORD_W-1:0] map_y;
  logic [COORD_W:0]   dx;
  logic [COORD_W:0]   dy;
  logic [COORD_W-1:0] adx;
  logic [COORD_W-1:0] ady;
  logic               is_swipe;
  logic               is_touch;

  // mirror, clamped to 0 when raw lies beyond the visible range
  assign map_x = (item.raw_x > cfg.max_x) ? '0 : cfg.max_x - item.raw_x;
  assign map_y = (item.raw_y > cfg.max_y) ? '0 : cfg.max_y - item.raw_y;

  assign dx  = {1'b0, st.last_x} - {1'b0, st.start_x};
  assign dy  = {1'b0, st.last_y} - {1'b0, st.start_y};
  assign adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

  assign is_swipe = st.pressed && (adx > cfg.swipe_min_dx) && (ady < cfg.swipe_max_dy);
  assign is_touch = item.ev_code inside {EV_DOWN, EV_CONTACT};

  always_comb begin
    st_nxt          = st;
    res             = '0;
    st_nxt.poll_cnt = st.poll_cnt + CNT_W'(1);
    if (!item.bus_ok) begin
      st_nxt.error_cnt = st.error_cnt + CNT_W'(1);
      res.bus_error    = 1'b1;
    end else begin
      st_nxt.good_cnt = st.good_cnt + CNT_W'(1);
      if (item.touch_count <= TOUCH_W'(MAX_TOUCHES)) begin
        st_nxt.touches = item.touch_count;
      end
      if (is_touch) begin
        if (!st.pressed) begin
          st_nxt.start_x = map_x;
          st_nxt.start_y = map_y;
        end
        st_nxt.last_x    = map_x;
        st_nxt.last_y    = map_y;
        st_nxt.pressed   = 1'b1;
        st_nxt.press_cnt = st.press_cnt + CNT_W'(1);
        res.is_pressed   = 1'b1;
      end else begin
        if (is_swipe) begin
          st_nxt.swipe_cnt = st.swipe_cnt + CNT_W'(1);
          res.swipe_valid  = 1'b1;
          res.swipe_right  = ~dx[COORD_W];
        end
        st_nxt.pressed = 1'b0;
      end
    end
    res.point_x      = st_nxt.last_x;
    res.point_y      = st_nxt.last_y;
    res.poll_count   = st_nxt.poll_cnt;
    res.good_count   = st_nxt.good_cnt;
    res.err_polls    = st_nxt.error_cnt;
    res.press_polls  = st_nxt.press_cnt;
    res.swipe_total  = st_nxt.swipe_cnt;
    res.last_touches = st_nxt.touches;
  end

endmodule

`default_nettype wire

// File: rtl/touch_swipe_tracker.sv
`default_nettype none

// channel | ports                                   | accepted when
// --------+-----------------------------------------+------------------------
// in      | in_valid, in_ready, in_<field>          | in_valid & in_ready
// out     | out_valid, out_ready, out_<field>       | out_valid & out_ready
// cfg     | cfg_we, cfg_index, cfg_wdata            | cfg_we
//
// One item per cycle sustained unless the output stalls; an accepted item goes
// to the input register, then through step logic into the result register.
// rst_n is synchronous, active low: clears tracking state and counters and
// loads the register defaults. A stalled output holds the result register and
// the input register in place; the input register still refills when empty.

module touch_swipe_tracker import tst_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_bus_ok,
  input  wire logic [1:0]           in_ev_code,
  input  wire logic [COORD_W-1:0]   in_raw_x,
  input  wire logic [COORD_W-1:0]   in_raw_y,
  input  wire logic [TOUCH_W-1:0]   in_touch_count,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [COORD_W-1:0]        out_point_x,
  output logic [COORD_W-1:0]        out_point_y,
  output logic                      out_is_pressed,
  output logic                      out_bus_error,
  output logic                      out_swipe_valid,
  output logic                      out_swipe_right,
  output logic [CNT_W-1:0]          out_poll_count,
  output logic [CNT_W-1:0]          out_good_count,
  output logic [CNT_W-1:0]          out_err_polls,
  output logic [CNT_W-1:0]          out_press_polls,
  output logic [CNT_W-1:0]          out_swipe_total,
  output logic [TOUCH_W-1:0]        out_last_touches,

  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic       s1_valid_r;
  tst_in_t    s1_item_r;
  logic       out_valid_r;
  tst_res_t   out_res_r;
  tst_state_t st_r;
  tst_state_t st_nxt;
  tst_cfg_t   cfg_r;
  tst_res_t   res;
  logic       advance;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  tst_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      st_r               <= '0;
      cfg_r.max_x        <= MAX_X_RST;
      cfg_r.max_y        <= MAX_Y_RST;
      cfg_r.swipe_min_dx <= SWIPE_MIN_DX_RST;
      cfg_r.swipe_max_dy <= SWIPE_MAX_DY_RST;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance && s1_valid_r) begin
        st_r <= st_nxt;
      end
      if (cfg_we) begin
        case (tst_reg_t'(cfg_index))
          REG_MAX_X:        cfg_r.max_x        <= cfg_wdata;
          REG_MAX_Y:        cfg_r.max_y        <= cfg_wdata;
          REG_SWIPE_MIN_DX: cfg_r.swipe_min_dx <= cfg_wdata;
          REG_SWIPE_MAX_DY: cfg_r.swipe_max_dy <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.bus_ok      <= in_bus_ok;
      s1_item_r.ev_code     <= in_ev_code;
      s1_item_r.raw_x       <= in_raw_x;
      s1_item_r.raw_y       <= in_raw_y;
      s1_item_r.touch_count <= in_touch_count;
    end
    if (advance && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_x      = out_res_r.point_x;
  assign out_point_y      = out_res_r.point_y;
  assign out_is_pressed   = out_res_r.is_pressed;
  assign out_bus_error    = out_res_r.bus_error;
  assign out_swipe_valid  = out_res_r.swipe_valid;
  assign out_swipe_right  = out_res_r.swipe_right;
  assign out_poll_count   = out_res_r.poll_count;
  assign out_good_count   = out_res_r.good_count;
  assign out_err_polls    = out_res_r.err_polls;
  assign out_press_polls  = out_res_r.press_polls;
  assign out_swipe_total  = out_res_r.swipe_total;
  assign out_last_touches = out_res_r.last_touches;

  // a swipe only closes a press on a good poll
  a_swipe_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.swipe_valid |-> !out_res_r.is_pressed && !out_res_r.bus_error)
    else $error("swipe reported on a pressed or failed poll");

  a_right_needs_swipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.swipe_valid |-> !out_res_r.swipe_right)
    else $error("swipe direction without a swipe");

  a_cnt_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.poll_count == out_res_r.good_count + out_res_r.err_polls)
    else $error("poll count differs from good plus error count");

  a_touch_limit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.touches <= TOUCH_W'(MAX_TOUCHES))
    else $error("stored touch count above the limit");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(st_r))
    else $error("tracking state moved while the output stalled");

endmodule

`default_nettype wire

// File: dv/touch_swipe_checker.sv
`timescale 1ns / 1ps

module touch_swipe_checker import tst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_bus_ok,
  input  logic [1:0]         in_ev_code,
  input  logic [COORD_W-1:0] in_raw_x,
  input  logic [COORD_W-1:0] in_raw_y,
  input  logic [TOUCH_W-1:0] in_touch_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [COORD_W-1:0] out_point_x,
  input  logic [COORD_W-1:0] out_point_y,
  input  logic               out_is_pressed,
  input  logic               out_bus_error,
  input  logic               out_swipe_valid,
  input  logic               out_swipe_right,
  input  logic [CNT_W-1:0]   out_poll_count,
  input  logic [CNT_W-1:0]   out_good_count,
  input  logic [CNT_W-1:0]   out_err_polls,
  input  logic [CNT_W-1:0]   out_press_polls,
  input  logic [CNT_W-1:0]   out_swipe_total,
  input  logic [TOUCH_W-1:0] out_last_touches,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  output int                 errors,
  output int                 pending
);

  tst_cfg_t   regs;
  tst_state_t trk;
  tst_res_t   poll_results[$];

  function automatic logic [COORD_W-1:0] mirror_coord(logic [COORD_W-1:0] raw,
                                                      logic [CFG_W-1:0] lim);
    return (raw > lim) ? '0 : COORD_W'(lim - raw);
  endfunction

  function automatic tst_res_t track_poll(tst_in_t p);
    tst_res_t r;
    int dx;
    int dy;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    r = '0;
    trk.poll_cnt += 1;
    if (!p.bus_ok) begin
      trk.error_cnt += 1;
    end else begin
      trk.good_cnt += 1;
      if (p.touch_count <= MAX_TOUCHES) trk.touches = p.touch_count;
      if (p.ev_code == EV_DOWN || p.ev_code == EV_CONTACT) begin
        nx = mirror_coord(p.raw_x, regs.max_x);
        ny = mirror_coord(p.raw_y, regs.max_y);
        if (!trk.pressed) begin
          trk.start_x = nx;
          trk.start_y = ny;
        end
        trk.last_x = nx;
        trk.last_y = ny;
        trk.pressed = 1'b1;
        trk.press_cnt += 1;
        r.is_pressed = 1'b1;
      end else begin
        if (trk.pressed) begin
          dx = int'(trk.last_x) - int'(trk.start_x);
          dy = int'(trk.last_y) - int'(trk.start_y);
          if ((dx < 0 ? -dx : dx) > int'(regs.swipe_min_dx) &&
              (dy < 0 ? -dy : dy) < int'(regs.swipe_max_dy)) begin
            trk.swipe_cnt += 1;
            r.swipe_valid = 1'b1;
            r.swipe_right = (dx > 0);
          end
        end
        trk.pressed = 1'b0;
      end
    end
    r.point_x      = trk.last_x;
    r.point_y      = trk.last_y;
    r.bus_error    = !p.bus_ok;
    r.poll_count   = trk.poll_cnt;
    r.good_count   = trk.good_cnt;
    r.err_polls    = trk.error_cnt;
    r.press_polls  = trk.press_cnt;
    r.swipe_total  = trk.swipe_cnt;
    r.last_touches = trk.touches;
    return r;
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    tst_res_t want;
    if (!rst_n) begin
      regs.max_x        = MAX_X_RST;
      regs.max_y        = MAX_Y_RST;
      regs.swipe_min_dx = SWIPE_MIN_DX_RST;
      regs.swipe_max_dy = SWIPE_MAX_DY_RST;
      trk               = '0;
      poll_results.delete();
      errors            = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (poll_results.size() == 0) begin
          $error("result item with no poll outstanding");
          errors++;
        end else begin
          want = poll_results.pop_front();
          check_field("point_x", want.point_x, out_point_x);
          check_field("point_y", want.point_y, out_point_y);
          check_field("is_pressed", want.is_pressed, out_is_pressed);
          check_field("bus_error", want.bus_error, out_bus_error);
          check_field("swipe_valid", want.swipe_valid, out_swipe_valid);
          check_field("swipe_right", want.swipe_right, out_swipe_right);
          check_field("poll_count", want.poll_count, out_poll_count);
          check_field("good_count", want.good_count, out_good_count);
          check_field("err_polls", want.err_polls, out_err_polls);
          check_field("press_polls", want.press_polls, out_press_polls);
          check_field("swipe_total", want.swipe_total, out_swipe_total);
          check_field("last_touches", want.last_touches, out_last_touches);
        end
      end
      if (in_valid && in_ready) begin
        poll_results.push_back(track_poll({in_bus_ok, in_ev_code, in_raw_x,
                                           in_raw_y, in_touch_count}));
      end
      if (cfg_we) begin
        case (tst_reg_t'(cfg_index))
          REG_MAX_X:        regs.max_x        = cfg_wdata;
          REG_MAX_Y:        regs.max_y        = cfg_wdata;
          REG_SWIPE_MIN_DX: regs.swipe_min_dx = cfg_wdata;
          REG_SWIPE_MAX_DY: regs.swipe_max_dy = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = poll_results.size();
  end

endmodule

// File: dv/touch_swipe_tracker_tb.sv
`timescale 1ns / 1ps

module touch_swipe_tracker_tb;
  import tst_pkg::*;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic                 in_bus_ok      = 1'b0;
  logic [1:0]           in_ev_code     = EV_NONE;
  logic [COORD_W-1:0]   in_raw_x       = '0;
  logic [COORD_W-1:0]   in_raw_y       = '0;
  logic [TOUCH_W-1:0]   in_touch_count = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [COORD_W-1:0]   out_point_x;
  logic [COORD_W-1:0]   out_point_y;
  logic                 out_is_pressed;
  logic                 out_bus_error;
  logic                 out_swipe_valid;
  logic                 out_swipe_right;
  logic [CNT_W-1:0]     out_poll_count;
  logic [CNT_W-1:0]     out_good_count;
  logic [CNT_W-1:0]     out_err_polls;
  logic [CNT_W-1:0]     out_press_polls;
  logic [CNT_W-1:0]     out_swipe_total;
  logic [TOUCH_W-1:0]   out_last_touches;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = REG_MAX_X;
  logic [CFG_W-1:0]     cfg_wdata      = '0;

  int errors;
  int pending;
  int src_idle   = 0;
  int sink_stall = 0;
  int polls_sent = 0;
  int cur_max_x  = 799;
  int cur_max_y  = 479;
  int cur_min_dx = 80;
  int cur_max_dy = 120;

  always #5 clk = ~clk;

  always @(negedge clk) out_ready <= ($urandom_range(99) >= sink_stall);

  touch_swipe_tracker i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_bus_ok(in_bus_ok),
    .in_ev_code(in_ev_code), .in_raw_x(in_raw_x), .in_raw_y(in_raw_y),
    .in_touch_count(in_touch_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_point_x(out_point_x),
    .out_point_y(out_point_y), .out_is_pressed(out_is_pressed),
    .out_bus_error(out_bus_error), .out_swipe_valid(out_swipe_valid),
    .out_swipe_right(out_swipe_right), .out_poll_count(out_poll_count),
    .out_good_count(out_good_count), .out_err_polls(out_err_polls),
    .out_press_polls(out_press_polls), .out_swipe_total(out_swipe_total),
    .out_last_touches(out_last_touches),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  touch_swipe_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_bus_ok(in_bus_ok),
    .in_ev_code(in_ev_code), .in_raw_x(in_raw_x), .in_raw_y(in_raw_y),
    .in_touch_count(in_touch_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_point_x(out_point_x),
    .out_point_y(out_point_y), .out_is_pressed(out_is_pressed),
    .out_bus_error(out_bus_error), .out_swipe_valid(out_swipe_valid),
    .out_swipe_right(out_swipe_right), .out_poll_count(out_poll_count),
    .out_good_count(out_good_count), .out_err_polls(out_err_polls),
    .out_press_polls(out_press_polls), .out_swipe_total(out_swipe_total),
    .out_last_touches(out_last_touches),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  function automatic int coord_clip(int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // called and returns at a falling edge
  task automatic send_poll(logic ok, tst_event_t ev, int rx, int ry, int tc);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_bus_ok      <= ok;
    in_ev_code     <= ev;
    in_raw_x       <= COORD_W'(coord_clip(rx));
    in_raw_y       <= COORD_W'(coord_clip(ry));
    in_touch_count <= TOUCH_W'(tc);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(tst_reg_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_config(int mx, int my, int mdx, int mdy);
    drain_results();
    write_reg(REG_MAX_X, mx);
    write_reg(REG_MAX_Y, my);
    write_reg(REG_SWIPE_MIN_DX, mdx);
    write_reg(REG_SWIPE_MAX_DY, mdy);
    cur_max_x  = mx;
    cur_max_y  = my;
    cur_min_dx = mdx;
    cur_max_dy = mdy;
  endtask

  function automatic int pick_touches();
    return ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(2, 1);
  endfunction

  task automatic random_poll();
    send_poll(1'($urandom_range(1)), tst_event_t'($urandom_range(3)), $urandom_range(4095),
              $urandom_range(4095), $urandom_range(15));
  endtask

  // down, a few contacts along a line, then usually a lift or none event
  task automatic gesture();
    int sx, sy, ex, ey, steps, span_x, span_y, sel;
    sx     = $urandom_range(coord_clip(cur_max_x + 40), 0);
    sy     = $urandom_range(coord_clip(cur_max_y + 40), 0);
    span_x = cur_min_dx * 2 + 60;
    span_y = cur_max_dy + 30;
    ex     = sx + $urandom_range(2 * span_x) - span_x;
    ey     = sy + $urandom_range(2 * span_y) - span_y;
    steps  = $urandom_range(5);
    send_poll(1'b1, EV_DOWN, sx, sy, pick_touches());
    for (int k = 1; k <= steps; k++) begin
      if ($urandom_range(99) < 8) random_poll();
      if ($urandom_range(99) < 6)
        send_poll(1'b0, tst_event_t'($urandom_range(3)), $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(15));
      send_poll(1'b1, EV_CONTACT, sx + (ex - sx) * k / steps, sy + (ey - sy) * k / steps,
                pick_touches());
    end
    sel = $urandom_range(9);
    if (sel < 7) begin
      send_poll(1'b1, EV_LIFT, $urandom_range(4095), $urandom_range(4095), pick_touches());
    end else if (sel < 9) begin
      send_poll(1'b1, EV_NONE, $urandom_range(4095), $urandom_range(4095), pick_touches());
    end
  endtask

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int phase_start;
    bit paused;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, register defaults
    send_poll(1'b1, EV_LIFT, 10, 10, 0);
    send_poll(1'b1, EV_NONE, 20, 20, 1);
    send_poll(1'b0, EV_DOWN, 30, 30, 2);
    send_poll(1'b1, EV_DOWN, 0, 0, 5);
    send_poll(1'b1, EV_CONTACT, 4095, 4095, 15);
    send_poll(1'b0, EV_LIFT, 100, 100, 3);
    send_poll(1'b1, EV_LIFT, 0, 0, 6);
    send_poll(1'b1, EV_DOWN, 700, 240, 1);
    send_poll(1'b1, EV_CONTACT, 500, 250, 1);
    send_poll(1'b1, EV_LIFT, 500, 250, 0);
    send_poll(1'b1, EV_DOWN, 100, 240, 2);
    send_poll(1'b1, EV_CONTACT, 600, 200, 2);
    send_poll(1'b1, EV_NONE, 0, 0, 4);
    send_poll(1'b1, EV_DOWN, 400, 100, 1);
    send_poll(1'b1, EV_CONTACT, 320, 100, 1);
    send_poll(1'b1, EV_LIFT, 0, 0, 1);
    send_poll(1'b1, EV_DOWN, 400, 100, 1);
    send_poll(1'b1, EV_CONTACT, 200, 220, 1);
    send_poll(1'b1, EV_LIFT, 0, 0, 1);
    send_poll(1'b1, EV_DOWN, 799, 479, 1);
    send_poll(1'b1, EV_CONTACT, 800, 480, 1);
    send_poll(1'b0, EV_NONE, 4095, 4095, 15);
    send_poll(1'b1, EV_NONE, 4095, 4095, 5);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_config(799, 479, 80, 120);
        1: load_config(4095, 4095, 300, 400);
        2: load_config($urandom_range(4095), $urandom_range(4095), $urandom_range(300),
                       $urandom_range(400, 50));
        3: load_config(0, 0, 4095, 0);
        default: load_config(4095, 4095, 0, 4095);
      endcase
      case (ph % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 72; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 72; end
        default: begin src_idle = 33; sink_stall = 33; end
      endcase
      phase_start = polls_sent;
      paused = 1'b0;
      while (polls_sent - phase_start < 380) begin
        if ($urandom_range(99) < 20) random_poll();
        else gesture();
        if (!paused && polls_sent - phase_start > 190) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
